/* hdl/assert_macros.svh */
// assertion macros shared by the quaternion unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define QALU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define QALU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hdl/qalu_pkg.sv */
// types and constants of the quaternion unit
package qalu_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int COMP_WIDTH = 16;
    localparam int PROD_W     = 2 * COMP_WIDTH;
    localparam int SUM_W      = ((PROD_W > FRAC_BITS + 1) ? PROD_W : FRAC_BITS + 1) + 4;

    localparam logic signed [SUM_W-1:0] SUM_MAX =
        SUM_W'((64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(64'sd1 <<< (COMP_WIDTH - 1));
    localparam logic signed [SUM_W-1:0] FIX_ONE = SUM_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [SUM_W-1:0] HALF_SGL = SUM_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0] HALF_DBL = SUM_W'(64'sd1 <<< (FRAC_BITS - 2));

    localparam logic [1:0] ROW_LAST = 2'd3;

    typedef logic signed [COMP_WIDTH-1:0] t_comp;

    typedef enum logic [2:0] {
        CMD_PRODUCT = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_SUB     = 3'd2,
        CMD_NEGATE  = 3'd3,
        CMD_CONJ    = 3'd4,
        CMD_SCALE   = 3'd5,
        CMD_MATRIX  = 3'd6
    } t_cmd;

    typedef struct packed {
        logic [2:0] cmd;
        t_comp      a_x;
        t_comp      a_y;
        t_comp      a_z;
        t_comp      a_w;
        t_comp      b_x;
        t_comp      b_y;
        t_comp      b_z;
        t_comp      b_w;
        t_comp      scale_factor;
    } t_in_item;

    typedef struct packed {
        t_comp      res_0;
        t_comp      res_1;
        t_comp      res_2;
        t_comp      res_3;
        logic [1:0] row_index;
        logic       last_result;
        logic       overflow;
    } t_out_item;

endpackage

/* hdl/qalu_ifs.sv */
// valid/ready channels carrying input and result items
interface qalu_in_if;
    import qalu_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface qalu_out_if;
    import qalu_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/qalu_datapath.sv */
// combinational datapath: one result item from a held item and a row number
module qalu_datapath (
    input  qalu_pkg::t_in_item  i_item,
    input  logic [1:0]          i_row,
    output qalu_pkg::t_out_item o_res
);
    import qalu_pkg::*;

    t_comp                   u_op [4][4];
    t_comp                   v_op [4][4];
    logic                    neg  [4][4];
    logic signed [SUM_W-1:0] lin  [4];
    logic                    dbl;
    logic signed [SUM_W-1:0] sum  [4];
    t_comp                   sat  [4];
    logic [3:0]              ovf;
    t_cmd                    cmd;
    t_comp                   ax, ay, az, aw, bx, by, bz, bw;

    assign cmd = t_cmd'(i_item.cmd);
    assign ax  = i_item.a_x;
    assign ay  = i_item.a_y;
    assign az  = i_item.a_z;
    assign aw  = i_item.a_w;
    assign bx  = i_item.b_x;
    assign by  = i_item.b_y;
    assign bz  = i_item.b_z;
    assign bw  = i_item.b_w;

    // operand selection: four product slots per component plus a linear term
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            lin[j] = '0;
            for (int k = 0; k < 4; k++) begin
                u_op[j][k] = '0;
                v_op[j][k] = '0;
                neg[j][k]  = 1'b0;
            end
        end
        dbl = 1'b0;
        unique case (cmd)
            CMD_PRODUCT: begin
                u_op[0][0] = ay; v_op[0][0] = bz;
                u_op[0][1] = az; v_op[0][1] = by; neg[0][1] = 1'b1;
                u_op[0][2] = ax; v_op[0][2] = bw;
                u_op[0][3] = aw; v_op[0][3] = bx;
                u_op[1][0] = az; v_op[1][0] = bx;
                u_op[1][1] = ax; v_op[1][1] = bz; neg[1][1] = 1'b1;
                u_op[1][2] = ay; v_op[1][2] = bw;
                u_op[1][3] = aw; v_op[1][3] = by;
                u_op[2][0] = ax; v_op[2][0] = by;
                u_op[2][1] = ay; v_op[2][1] = bx; neg[2][1] = 1'b1;
                u_op[2][2] = az; v_op[2][2] = bw;
                u_op[2][3] = aw; v_op[2][3] = bz;
                u_op[3][0] = aw; v_op[3][0] = bw;
                u_op[3][1] = ax; v_op[3][1] = bx; neg[3][1] = 1'b1;
                u_op[3][2] = ay; v_op[3][2] = by; neg[3][2] = 1'b1;
                u_op[3][3] = az; v_op[3][3] = bz; neg[3][3] = 1'b1;
            end
            CMD_ADD: begin
                lin[0] = SUM_W'(ax) + SUM_W'(bx);
                lin[1] = SUM_W'(ay) + SUM_W'(by);
                lin[2] = SUM_W'(az) + SUM_W'(bz);
                lin[3] = SUM_W'(aw) + SUM_W'(bw);
            end
            CMD_SUB: begin
                lin[0] = SUM_W'(ax) - SUM_W'(bx);
                lin[1] = SUM_W'(ay) - SUM_W'(by);
                lin[2] = SUM_W'(az) - SUM_W'(bz);
                lin[3] = SUM_W'(aw) - SUM_W'(bw);
            end
            CMD_NEGATE: begin
                lin[0] = -SUM_W'(ax);
                lin[1] = -SUM_W'(ay);
                lin[2] = -SUM_W'(az);
                lin[3] = -SUM_W'(aw);
            end
            CMD_CONJ: begin
                lin[0] = -SUM_W'(ax);
                lin[1] = -SUM_W'(ay);
                lin[2] = -SUM_W'(az);
                lin[3] = SUM_W'(aw);
            end
            CMD_SCALE: begin
                u_op[0][0] = ax; v_op[0][0] = i_item.scale_factor;
                u_op[1][0] = ay; v_op[1][0] = i_item.scale_factor;
                u_op[2][0] = az; v_op[2][0] = i_item.scale_factor;
                u_op[3][0] = aw; v_op[3][0] = i_item.scale_factor;
            end
            CMD_MATRIX: begin
                dbl = 1'b1;
                unique case (i_row)
                    2'd0: begin
                        lin[0] = FIX_ONE;
                        u_op[0][0] = ay; v_op[0][0] = ay; neg[0][0] = 1'b1;
                        u_op[0][1] = az; v_op[0][1] = az; neg[0][1] = 1'b1;
                        u_op[1][0] = ax; v_op[1][0] = ay;
                        u_op[1][1] = az; v_op[1][1] = aw; neg[1][1] = 1'b1;
                        u_op[2][0] = ax; v_op[2][0] = az;
                        u_op[2][1] = ay; v_op[2][1] = aw;
                    end
                    2'd1: begin
                        u_op[0][0] = ax; v_op[0][0] = ay;
                        u_op[0][1] = az; v_op[0][1] = aw;
                        lin[1] = FIX_ONE;
                        u_op[1][0] = ax; v_op[1][0] = ax; neg[1][0] = 1'b1;
                        u_op[1][1] = az; v_op[1][1] = az; neg[1][1] = 1'b1;
                        u_op[2][0] = ay; v_op[2][0] = az;
                        u_op[2][1] = ax; v_op[2][1] = aw; neg[2][1] = 1'b1;
                    end
                    2'd2: begin
                        u_op[0][0] = ax; v_op[0][0] = az;
                        u_op[0][1] = ay; v_op[0][1] = aw; neg[0][1] = 1'b1;
                        u_op[1][0] = ay; v_op[1][0] = az;
                        u_op[1][1] = ax; v_op[1][1] = aw;
                        lin[2] = FIX_ONE;
                        u_op[2][0] = ax; v_op[2][0] = ax; neg[2][0] = 1'b1;
                        u_op[2][1] = ay; v_op[2][1] = ay; neg[2][1] = 1'b1;
                    end
                    default: begin
                        lin[3] = FIX_ONE;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // round each product on its own (ties up), sum exactly, saturate once
    always_comb begin
        logic signed [PROD_W-1:0] prod;
        logic signed [SUM_W-1:0]  rnd;
        for (int j = 0; j < 4; j++) begin
            sum[j] = lin[j];
            for (int k = 0; k < 4; k++) begin
                prod = u_op[j][k] * v_op[j][k];
                if (dbl) begin
                    rnd = (SUM_W'(prod) + HALF_DBL) >>> (FRAC_BITS - 1);
                end else begin
                    rnd = (SUM_W'(prod) + HALF_SGL) >>> FRAC_BITS;
                end
                sum[j] = neg[j][k] ? sum[j] - rnd : sum[j] + rnd;
            end
            if (sum[j] > SUM_MAX) begin
                sat[j] = COMP_WIDTH'(SUM_MAX);
                ovf[j] = 1'b1;
            end else if (sum[j] < SUM_MIN) begin
                sat[j] = COMP_WIDTH'(SUM_MIN);
                ovf[j] = 1'b1;
            end else begin
                sat[j] = COMP_WIDTH'(sum[j]);
                ovf[j] = 1'b0;
            end
        end
    end

    assign o_res.res_0       = sat[0];
    assign o_res.res_1       = sat[1];
    assign o_res.res_2       = sat[2];
    assign o_res.res_3       = sat[3];
    assign o_res.row_index   = (cmd == CMD_MATRIX) ? i_row : 2'd0;
    assign o_res.last_result = (cmd != CMD_MATRIX) || (i_row == ROW_LAST);
    assign o_res.overflow    = |ovf;

endmodule

/* hdl/quaternion_alu.sv */
// top level of the quaternion unit: item register, datapath, result register
//
//  channel  dir  carries                                         handshake
//  i_in     in   cmd, a_x..a_w, b_x..b_w, scale_factor           valid/ready
//  o_out    out  res_0..res_3, row_index, last_result, overflow  valid/ready
//
// while o_out is not stalled, one item per cycle for vector commands; the rotation
// matrix holds the item register, one matrix row per cycle through the datapath
// an accepted item is held in the item register, its results in the result register
// the item register frees as its last result moves into the result register,
// so a new item enters while that result still waits downstream
// a stalled o_out holds the result register and then the item register
// synchronous active-low reset clears the valid flags and the row counter
module quaternion_alu (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qalu_in_if.sink          i_in,
    qalu_out_if.source       o_out
);
    import qalu_pkg::*;

    `include "assert_macros.svh"

    // item register and matrix row counter
    t_in_item   r_in;
    logic       r_in_valid, n_in_valid;
    logic [1:0] r_row, n_row;

    // result register
    t_out_item  r_out;
    logic       r_out_valid, n_out_valid;

    t_out_item  w_res;
    logic       w_advance;
    logic       w_take;

    qalu_datapath u_dp (
        .i_item (r_in),
        .i_row  (r_row),
        .o_res  (w_res)
    );

    // a result moves into the result register when that register is free or drains
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || (w_advance && w_res.last_result);
    assign w_take     = i_in.valid && i_in.ready;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_row       = r_row;
        n_out_valid = r_out_valid;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_advance) begin
            n_out_valid = 1'b1;
            if (w_res.last_result) begin
                n_in_valid = 1'b0;
                n_row      = '0;
            end else begin
                n_row = r_row + 2'd1;
            end
        end
        if (w_take) begin
            n_in_valid = 1'b1;
            n_row      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_in.payload;
        end
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // only a matrix item ever sits on a nonzero row
    `QALU_ASSERT_IMP(a_row_matrix_only, i_clk, i_rst_n,
        r_in_valid && (r_in.cmd != CMD_MATRIX), r_row == 2'd0)
    // a non-final row keeps the item and steps to the next row
    `QALU_ASSERT_NXT(a_row_steps, i_clk, i_rst_n,
        w_advance && !w_res.last_result, r_in_valid && (r_row == $past(r_row) + 2'd1))
    // the last matrix row always closes the item
    `QALU_ASSERT_IMP(a_last_row_closes, i_clk, i_rst_n,
        r_out_valid && (r_out.row_index == ROW_LAST), r_out.last_result)
    // no new item is taken while a matrix still has rows to emit
    `QALU_ASSERT_IMP(a_no_take_mid_matrix, i_clk, i_rst_n,
        r_in_valid && !w_res.last_result, !w_take)

endmodule
